[rtl/pscr_pkg.sv]
// pscr_pkg: shared types and constants of the PID screw axis block.
// Used by pscr_smul, pscr_div and pid_screw_axis_simulator; no dependencies.
package pscr_pkg;

	localparam int VAL_W   = 32;
	localparam int INTEG_W = 48;
	localparam int MAG_A_W = 48;
	localparam int MAG_B_W = 32;
	localparam int RES_W   = 62;
	localparam int FRAC    = 16;

	localparam logic [RES_W-1:0] PROD_CAP = RES_W'(64'h1000_0000_0000_0000);

	typedef enum logic [2:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_LIM  = 3'd3,
		REG_LEN  = 3'd4,
		REG_APT  = 3'd5,
		REG_LOAD = 3'd6,
		REG_DRAG = 3'd7
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ERR, ST_INT, ST_DCHK, ST_DIV, ST_KP, ST_KI, ST_KD,
		ST_CLAMP, ST_NP, ST_ACC, ST_DRAG, ST_SO, ST_SA, ST_DONE
	} state_t;

	typedef enum logic [1:0] {MP_IDLE, MP_LO, MP_HI, MP_FIN} mul_phase_t;

	typedef struct packed {
		logic               start;
		logic [MAG_A_W-1:0] a;
		logic [MAG_B_W-1:0] b;
		logic               neg;
		logic               sh32;
	} mul_req_t;

	typedef struct packed {
		logic        start;
		logic [31:0] num;
		logic [31:0] den;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi)
			return 32'sh7FFF_FFFF;
		else if (v < lo)
			return -32'sh8000_0000;
		else
			return v[31:0];
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_7FFF_FFFF_FFFF;
		lo = -64'sh0000_8000_0000_0000;
		if (v > hi)
			return 48'sh7FFF_FFFF_FFFF;
		else if (v < lo)
			return -48'sh8000_0000_0000;
		else
			return v[47:0];
	endfunction

endpackage

[rtl/pscr_smul.sv]
// pscr_smul: sign-magnitude multiply of a 48 bit by a 32 bit magnitude,
// shifted right by 16 or 32 and capped at 2^60. One 32x32 multiplier, two passes.
// Depends on pscr_pkg.
module pscr_smul (
	input  logic                                clk,
	input  logic                                arst_n,
	input  pscr_pkg::mul_req_t                  req,
	output logic                                done,
	output logic signed [pscr_pkg::RES_W-1:0]   res
);

	pscr_pkg::mul_phase_t phase_q, phase_d;
	logic [pscr_pkg::MAG_A_W-1:0] a_q;
	logic [pscr_pkg::MAG_B_W-1:0] b_q;
	logic                         neg_q;
	logic                         sh_q;
	logic [63:0]                  prod_q;
	logic [63:0]                  lo_q;
	logic signed [pscr_pkg::RES_W-1:0] res_q;
	logic                         done_q;

	logic [31:0] mop;
	logic [63:0] p;
	logic [95:0] full;
	logic [63:0] shifted;
	logic [pscr_pkg::RES_W-1:0] mag;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			pscr_pkg::MP_IDLE: if (req.start) phase_d = pscr_pkg::MP_LO;
			pscr_pkg::MP_LO:   phase_d = pscr_pkg::MP_HI;
			pscr_pkg::MP_HI:   phase_d = pscr_pkg::MP_FIN;
			pscr_pkg::MP_FIN:  phase_d = pscr_pkg::MP_IDLE;
			default:           phase_d = pscr_pkg::MP_IDLE;
		endcase
	end

	always_comb begin
		mop  = (phase_q == pscr_pkg::MP_LO) ? a_q[31:0] : {16'b0, a_q[47:32]};
		p    = {32'b0, mop} * {32'b0, b_q};
		full = {prod_q, 32'b0} + {32'b0, lo_q};
		// product stays below 2^80, so the top of full is zero
		shifted = sh_q ? full[95:32] : full[79:16];
		if (shifted > 64'(pscr_pkg::PROD_CAP))
			mag = pscr_pkg::PROD_CAP;
		else
			mag = shifted[pscr_pkg::RES_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pscr_pkg::MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			done_q  <= (phase_q == pscr_pkg::MP_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (phase_q == pscr_pkg::MP_IDLE && req.start) begin
			a_q   <= req.a;
			b_q   <= req.b;
			neg_q <= req.neg;
			sh_q  <= req.sh32;
		end
		if (phase_q == pscr_pkg::MP_LO)
			prod_q <= p;
		if (phase_q == pscr_pkg::MP_HI) begin
			lo_q   <= prod_q;
			prod_q <= p;
		end
		if (phase_q == pscr_pkg::MP_FIN)
			res_q <= neg_q ? -$signed(mag) : $signed(mag);
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/pscr_div.sv]
// pscr_div: restoring divider, (num << 32) / den for num < den, one bit a cycle.
// Depends on pscr_pkg.
module pscr_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pscr_pkg::div_req_t req,
	output logic               done,
	output logic [31:0]        quo
);

	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [31:0] quo_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] t;
	logic        ge;

	always_comb begin
		t  = {rem_q, 1'b0};
		ge = (t >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			rem_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? 32'(t - {1'b0, den_q}) : t[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

[rtl/pid_screw_axis_simulator.sv]
// pid_screw_axis_simulator: PID position loop driving an Euler model of a screw axis.
// Depends on pscr_pkg, pscr_smul and pscr_div.
//
// Channels: config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken; write them while the block is idle. Input beats (in_valid/in_ready)
// carry command, elapsed_time and target_position; every input beat gives
// exactly one output beat (out_valid/out_ready) with position, speed, torque,
// saturated and halted.
// Flow: a reset command or a tick while halted goes straight to the done
// state. A normal tick runs through one shared 32x32 multiplier for 6 to 9
// products, plus the serial divider when the derivative is updated from a
// difference smaller than elapsed_time. in_ready is high only between items.
// The result sits in an output register; the next item is accepted while it
// waits, and a finished tick holds in its last step until that register frees.
// Reset clears all gains, limits and axis state to zero; no output is pending.
module pid_screw_axis_simulator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               command,
	input  logic [31:0]        elapsed_time,
	input  logic signed [31:0] target_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] position_out,
	output logic signed [31:0] speed_out,
	output logic signed [31:0] torque_out,
	output logic               saturated,
	output logic               halted
);

	localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VMIN = -32'sh8000_0000;

	pscr_pkg::state_t state_q, state_d;

	logic signed [31:0] kp_q, ki_q, kd_q, apt_q, load_q;
	logic [30:0]        lim_q, len_q, drag_q;

	logic signed [31:0] pos_q, spd_q, trq_q, deriv_q, last_q, err_q;
	logic signed [47:0] integ_q;
	logic               stop_q;
	logic [31:0]        dt_q;
	logic signed [31:0] tgt_q;
	logic               sat_q;
	logic signed [63:0] pid_q;
	logic signed [33:0] newpos_q;
	logic signed [48:0] accel_q;
	logic signed [32:0] onem_q;
	logic signed [49:0] spdacc_q;
	logic               dneg_q;
	logic [31:0]        md_q;
	logic               iss_q;

	logic               ov_q, osat_q, ohalt_q;
	logic signed [31:0] opos_q, ospd_q, otrq_q;

	pscr_pkg::mul_req_t mreq;
	pscr_pkg::div_req_t dreq;
	logic               mdone, ddone;
	logic signed [pscr_pkg::RES_W-1:0] mres;
	logic [31:0]        dquo;

	logic signed [32:0] diff_d;
	logic [32:0]        md;
	logic               kd_upd;
	logic               in_acc;
	logic               out_free;
	logic               mul_st;
	logic signed [63:0] lim64;
	logic signed [63:0] pid_abs;

	pscr_smul u_mul (.clk(clk), .arst_n(arst_n), .req(mreq), .done(mdone), .res(mres));
	pscr_div  u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .done(ddone), .quo(dquo));

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	always_comb begin
		diff_d   = 33'(err_q) - 33'(last_q);
		md       = diff_d[32] ? 33'(-diff_d) : 33'(diff_d);
		kd_upd   = (kd_q != 0) && (dt_q != 0);
		in_acc   = in_valid && in_ready;
		out_free = !ov_q || out_ready;
		lim64    = $signed({33'b0, lim_q});
		pid_abs  = pid_q[63] ? -pid_q : pid_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pscr_pkg::ST_IDLE:
				if (in_valid)
					state_d = (command || stop_q) ? pscr_pkg::ST_DONE : pscr_pkg::ST_ERR;
			pscr_pkg::ST_ERR:
				state_d = (ki_q != 0) ? pscr_pkg::ST_INT : pscr_pkg::ST_DCHK;
			pscr_pkg::ST_INT:
				if (mdone) state_d = pscr_pkg::ST_DCHK;
			pscr_pkg::ST_DCHK:
				state_d = (kd_upd && md < {1'b0, dt_q}) ? pscr_pkg::ST_DIV : pscr_pkg::ST_KP;
			pscr_pkg::ST_DIV:
				if (ddone) state_d = pscr_pkg::ST_KP;
			pscr_pkg::ST_KP:
				if (mdone)
					state_d = (ki_q != 0) ? pscr_pkg::ST_KI :
						((kd_q != 0) ? pscr_pkg::ST_KD : pscr_pkg::ST_CLAMP);
			pscr_pkg::ST_KI:
				if (mdone) state_d = (kd_q != 0) ? pscr_pkg::ST_KD : pscr_pkg::ST_CLAMP;
			pscr_pkg::ST_KD:
				if (mdone) state_d = pscr_pkg::ST_CLAMP;
			pscr_pkg::ST_CLAMP:
				state_d = pscr_pkg::ST_NP;
			pscr_pkg::ST_NP:
				if (mdone) state_d = pscr_pkg::ST_ACC;
			pscr_pkg::ST_ACC:
				if (mdone) state_d = pscr_pkg::ST_DRAG;
			pscr_pkg::ST_DRAG:
				if (mdone) state_d = pscr_pkg::ST_SO;
			pscr_pkg::ST_SO:
				if (mdone) state_d = pscr_pkg::ST_SA;
			pscr_pkg::ST_SA:
				if (mdone) state_d = pscr_pkg::ST_DONE;
			pscr_pkg::ST_DONE:
				if (out_free) state_d = pscr_pkg::ST_IDLE;
			default:
				state_d = pscr_pkg::ST_IDLE;
		endcase
	end

	// outputs and shared-unit operands
	always_comb begin
		in_ready   = (state_q == pscr_pkg::ST_IDLE);
		cfg_ready  = 1'b1;
		mreq       = '0;
		dreq       = '0;
		mul_st     = 1'b1;
		unique case (state_q)
			pscr_pkg::ST_INT: begin
				mreq.a = 48'(mag32(err_q)); mreq.b = dt_q;
				mreq.neg = err_q[31]; mreq.sh32 = 1'b1;
			end
			pscr_pkg::ST_KP: begin
				mreq.a = 48'(mag32(err_q)); mreq.b = mag32(kp_q);
				mreq.neg = err_q[31] ^ kp_q[31];
			end
			pscr_pkg::ST_KI: begin
				mreq.a = integ_q[47] ? 48'(-integ_q) : 48'(integ_q);
				mreq.b = mag32(ki_q); mreq.neg = integ_q[47] ^ ki_q[31];
			end
			pscr_pkg::ST_KD: begin
				mreq.a = 48'(mag32(deriv_q)); mreq.b = mag32(kd_q);
				mreq.neg = deriv_q[31] ^ kd_q[31];
			end
			pscr_pkg::ST_NP: begin
				mreq.a = 48'(mag32(spd_q)); mreq.b = dt_q;
				mreq.neg = spd_q[31]; mreq.sh32 = 1'b1;
			end
			pscr_pkg::ST_ACC: begin
				mreq.a = 48'(mag32(trq_q)); mreq.b = mag32(apt_q);
				mreq.neg = trq_q[31] ^ apt_q[31];
			end
			pscr_pkg::ST_DRAG: begin
				mreq.a = {17'b0, drag_q}; mreq.b = dt_q; mreq.sh32 = 1'b1;
			end
			pscr_pkg::ST_SO: begin
				mreq.a = 48'(mag32(spd_q));
				mreq.b = onem_q[32] ? 32'(-onem_q) : 32'(onem_q);
				mreq.neg = spd_q[31] ^ onem_q[32];
			end
			pscr_pkg::ST_SA: begin
				mreq.a = accel_q[48] ? 48'(-accel_q) : 48'(accel_q);
				mreq.b = dt_q; mreq.neg = accel_q[48]; mreq.sh32 = 1'b1;
			end
			default: mul_st = 1'b0;
		endcase
		mreq.start = mul_st && !iss_q;
		dreq.start = (state_q == pscr_pkg::ST_DIV) && !iss_q;
		dreq.num   = md_q;
		dreq.den   = dt_q;
	end

	assign out_valid    = ov_q;
	assign position_out = opos_q;
	assign speed_out    = ospd_q;
	assign torque_out   = otrq_q;
	assign saturated    = osat_q;
	assign halted       = ohalt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pscr_pkg::ST_IDLE;
			iss_q   <= 1'b0;
			ov_q    <= 1'b0;
			kp_q <= '0; ki_q <= '0; kd_q <= '0; lim_q <= '0;
			len_q <= '0; apt_q <= '0; load_q <= '0; drag_q <= '0;
			pos_q <= '0; spd_q <= '0; trq_q <= '0; integ_q <= '0;
			deriv_q <= '0; last_q <= '0; stop_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mreq.start || dreq.start)
				iss_q <= 1'b1;
			else if (mdone || ddone)
				iss_q <= 1'b0;

			if (cfg_valid) begin
				unique case (pscr_pkg::cfg_reg_t'(cfg_index))
					pscr_pkg::REG_KP:   kp_q   <= cfg_data;
					pscr_pkg::REG_KI:   ki_q   <= cfg_data;
					pscr_pkg::REG_KD:   kd_q   <= cfg_data;
					pscr_pkg::REG_LIM:  lim_q  <= cfg_data[30:0];
					pscr_pkg::REG_LEN:  len_q  <= cfg_data[30:0];
					pscr_pkg::REG_APT:  apt_q  <= cfg_data;
					pscr_pkg::REG_LOAD: load_q <= cfg_data;
					pscr_pkg::REG_DRAG: drag_q <= cfg_data[30:0];
					default: ;
				endcase
			end

			if (state_q == pscr_pkg::ST_DONE && out_free)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;

			unique case (state_q)
				pscr_pkg::ST_IDLE:
					if (in_acc && command) begin
						pos_q   <= 32'(len_q >> 1);
						spd_q   <= '0;
						trq_q   <= '0;
						integ_q <= '0;
						deriv_q <= '0;
						last_q  <= '0;
						stop_q  <= 1'b0;
					end
				pscr_pkg::ST_INT:
					if (mdone) integ_q <= pscr_pkg::sat48(64'(integ_q) + 64'(mres));
				pscr_pkg::ST_DCHK: begin
					last_q <= err_q;
					if (kd_upd && md >= {1'b0, dt_q})
						deriv_q <= diff_d[32] ? VMIN : VMAX;
				end
				pscr_pkg::ST_DIV:
					if (ddone) begin
						if (dneg_q)
							deriv_q <= dquo[31] ? VMIN : -$signed(dquo);
						else
							deriv_q <= dquo[31] ? VMAX : $signed(dquo);
					end
				pscr_pkg::ST_CLAMP:
					if (pid_q > 0)
						trq_q <= (pid_q < lim64) ? 32'(pid_q) : 32'(lim64);
					else
						trq_q <= (pid_q > -lim64) ? 32'(pid_q) : 32'(-lim64);
				pscr_pkg::ST_SA:
					if (mdone) begin
						spd_q <= pscr_pkg::sat32(64'(spdacc_q) + 64'(mres));
						pos_q <= pscr_pkg::sat32(64'(newpos_q));
						if (newpos_q < 0 || newpos_q > $signed({3'b0, len_q}))
							stop_q <= 1'b1;
					end
				default: ;
			endcase
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			dt_q  <= elapsed_time;
			tgt_q <= target_position;
			sat_q <= 1'b0;
		end
		case (state_q) inside
			pscr_pkg::ST_ERR:
				err_q <= pscr_pkg::sat32(64'(tgt_q) - 64'(pos_q));
			pscr_pkg::ST_DCHK: begin
				dneg_q <= diff_d[32];
				md_q   <= md[31:0];
			end
			pscr_pkg::ST_KP:
				if (mdone) pid_q <= 64'(mres);
			pscr_pkg::ST_KI, pscr_pkg::ST_KD:
				if (mdone) pid_q <= pid_q + 64'(mres);
			pscr_pkg::ST_CLAMP:
				sat_q <= (pid_abs >= lim64);
			pscr_pkg::ST_NP:
				if (mdone) newpos_q <= 34'(pos_q) + 34'(mres);
			pscr_pkg::ST_ACC:
				if (mdone) accel_q <= 49'(mres) - 49'(load_q);
			pscr_pkg::ST_DRAG:
				if (mdone) onem_q <= $signed(33'(1) << pscr_pkg::FRAC) - 33'(mres);
			pscr_pkg::ST_SO:
				if (mdone) spdacc_q <= 50'(mres);
			default: ;
		endcase
		if (state_q == pscr_pkg::ST_DONE && out_free) begin
			opos_q  <= pos_q;
			ospd_q  <= spd_q;
			otrq_q  <= trq_q;
			osat_q  <= sat_q;
			ohalt_q <= stop_q;
		end
	end

endmodule
